// ===== design/bmhq_pkg.sv =====
package bmhq_pkg;

    // heap geometry
    localparam int CAPACITY = 256;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CHILD_W  = IDX_W + 2;

    // field widths
    localparam int KEY_W     = 32;
    localparam int ENTRY_W   = 9;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = KEY_W;
    localparam int M_TDATA_W = ((KEY_W + 1 + ENTRY_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - KEY_W - 1 - ENTRY_W;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic
    {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_e;

    typedef enum logic [STATUS_W-1:0]
    {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_e;

    typedef struct packed
    {
        op_e                     op;
        logic signed [KEY_W-1:0] key;
    } cmd_t;

    typedef struct packed
    {
        status_e                 status;
        logic signed [KEY_W-1:0] top_key;
        logic                    top_valid;
        logic [ENTRY_W-1:0]      entry_count;
    } res_t;

    // signed key order
    function automatic logic key_less(input logic signed [KEY_W-1:0] a,
                                      input logic signed [KEY_W-1:0] b);
        return a < b;
    endfunction

endpackage

// ===== design/bmhq_ram.sv =====
module bmhq_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/bmhq_front.sv =====
module bmhq_front
    import bmhq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic cmd_valid,
    input  logic cmd_take,
    output cmd_t cmd
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] fill_reg, fill_next;
    logic              push_beat;
    logic              pop_beat;

    assign in_ready  = (fill_reg != QCNT_W'(QUEUE_DEPTH));
    assign cmd_valid = (fill_reg != '0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign push_beat = in_valid && in_ready;
    assign pop_beat  = cmd_valid && cmd_take;

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push_beat)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_beat)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push_beat, pop_beat})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // queue slots, payload only
    always_ff @(posedge clk)
    begin
        if (push_beat)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ===== design/bmhq_engine.sv =====
module bmhq_engine
    import bmhq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_take,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    typedef enum logic [8:0]
    {
        S_IDLE    = 9'b000000001,
        S_UP_RD   = 9'b000000010,
        S_UP_CMP  = 9'b000000100,
        S_DN_LAST = 9'b000001000,
        S_DN_KEY  = 9'b000010000,
        S_DN_RDL  = 9'b000100000,
        S_DN_RDR  = 9'b001000000,
        S_DN_CMP  = 9'b010000000,
        S_FIN     = 9'b100000000
    } state_t;

    state_t                  state_reg, state_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic signed [KEY_W-1:0] child_reg, child_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    status_e                 status_reg, status_next;
    logic signed [KEY_W-1:0] root_reg, root_next;
    logic                    res_valid_reg, res_valid_next;
    res_t                    res_reg, res_next;

    logic                    we;
    logic [IDX_W-1:0]        waddr;
    logic signed [KEY_W-1:0] wdata;
    logic                    re;
    logic [IDX_W-1:0]        raddr;
    logic [KEY_W-1:0]        rdata_raw;
    logic signed [KEY_W-1:0] rdata;

    logic [IDX_W-1:0]        parent;
    logic [CHILD_W-1:0]      lc;
    logic [CHILD_W-1:0]      rc;
    logic                    lc_ok;
    logic                    rc_ok;
    logic                    left_wins;
    logic signed [KEY_W-1:0] best_val;
    logic [CHILD_W-1:0]      best_idx;
    logic                    moved;

    bmhq_ram
    #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    )
    u_store
    (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata_raw)
    );

    assign rdata = $signed(rdata_raw);

    // tree neighbours of the current slot
    assign parent = IDX_W'((pos_reg - 1'b1) >> 1);
    assign lc     = {1'b0, pos_reg, 1'b1};
    assign rc     = lc + 1'b1;
    assign lc_ok  = lc < CHILD_W'(cnt_reg);
    assign rc_ok  = rc < CHILD_W'(cnt_reg);

    // pick the strictly smaller child, left wins ties
    always_comb
    begin
        left_wins = key_less(child_reg, key_reg);
        best_val  = left_wins ? child_reg : key_reg;
        best_idx  = left_wins ? lc : CHILD_W'(pos_reg);
        moved     = left_wins;
        if (rc_ok && key_less(rdata, best_val))
        begin
            best_val = rdata;
            best_idx = rc;
            moved    = 1'b1;
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        key_next       = key_reg;
        child_next     = child_reg;
        cnt_next       = cnt_reg;
        status_next    = status_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        we             = 1'b0;
        waddr          = pos_reg;
        wdata          = key_reg;
        re             = 1'b0;
        raddr          = pos_reg;
        cmd_take       = 1'b0;

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take    = 1'b1;
                    status_next = ST_DONE;
                    if (cmd.op == OP_PUSH)
                    begin
                        if (cnt_reg == CNT_W'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            pos_next   = cnt_reg[IDX_W-1:0];
                            key_next   = cmd.key;
                            cnt_next   = cnt_reg + 1'b1;
                            state_next = S_UP_RD;
                        end
                    end
                    else
                    begin
                        if (cnt_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            cnt_next   = cnt_reg - 1'b1;
                            state_next = (cnt_reg == CNT_W'(1)) ? S_FIN : S_DN_LAST;
                        end
                    end
                end
            end
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    we         = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    re         = 1'b1;
                    raddr      = parent;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                we = 1'b1;
                if (key_less(key_reg, rdata))
                begin
                    wdata      = rdata;
                    pos_next   = parent;
                    state_next = S_UP_RD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_DN_LAST:
            begin
                // fetch the last entry, it restarts from the root
                re         = 1'b1;
                raddr      = cnt_reg[IDX_W-1:0];
                pos_next   = '0;
                state_next = S_DN_KEY;
            end
            S_DN_KEY:
            begin
                key_next   = rdata;
                state_next = S_DN_RDL;
            end
            S_DN_RDL:
            begin
                if (lc_ok)
                begin
                    re         = 1'b1;
                    raddr      = lc[IDX_W-1:0];
                    state_next = S_DN_RDR;
                end
                else
                begin
                    we         = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_DN_RDR:
            begin
                child_next = rdata;
                if (rc_ok)
                begin
                    re    = 1'b1;
                    raddr = rc[IDX_W-1:0];
                end
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                we = 1'b1;
                if (moved)
                begin
                    wdata      = best_val;
                    pos_next   = best_idx[IDX_W-1:0];
                    state_next = S_DN_RDL;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next       = 1'b1;
                    res_next.status      = status_reg;
                    res_next.top_valid   = (cnt_reg != '0);
                    res_next.top_key     = (cnt_reg != '0) ? root_reg : '0;
                    res_next.entry_count = ENTRY_W'(cnt_reg);
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // shadow of the root entry
    assign root_next = (we && waddr == '0) ? wdata : root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        key_reg    <= key_next;
        child_reg  <= child_next;
        status_reg <= status_next;
        root_reg   <= root_next;
        res_reg    <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== design/binary_min_heap_queue.sv =====
// min-heap priority queue of signed 32-bit keys, up to CAPACITY entries
// slave side: one beat per command, tuser selects push (0) or pop (1),
// tdata carries the key, ignored on pop
// master side: one beat per command with status in tuser and the current
// minimum, its valid flag and the entry count in tdata
// a two-beat command queue takes beats while the heap engine works, so the
// slave side only stalls when that queue is full
// the engine handles one command at a time through a heap memory with one
// write port and one registered read port: a push reads the parent at each
// level climbed, a pop reads the last entry, restarts it from the root and
// reads the left child and, if present, the right child at each level
// descended, and a pop that takes the last key needs no memory access
// each slave beat is registered in the command queue before the engine takes it
// a full-heap push or an empty-heap pop changes nothing
// reset empties heap, command queue and result slot, heap memory is kept
// when the master side stalls the result is held and the engine waits
// before its next result, further commands collect in the queue
module binary_min_heap_queue
    import bmhq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // key
    input  logic                 s_tuser,   // command
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // top_key, top_valid, entry_count, zero pad
    output logic [STATUS_W-1:0]  m_tuser    // status
);

    cmd_t in_cmd;
    cmd_t cmd;
    logic cmd_valid;
    logic cmd_take;
    res_t res;

    assign in_cmd.op  = op_e'(s_tuser);
    assign in_cmd.key = $signed(s_tdata[KEY_W-1:0]);

    bmhq_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (in_cmd),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd)
    );

    bmhq_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // result beat packing
    assign m_tdata = {{M_PAD_W{1'b0}}, res.entry_count, res.top_valid, res.top_key};
    assign m_tuser = res.status;

endmodule

// ===== design/bmhq_checker.sv =====
module bmhq_checker
    import bmhq_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [STATUS_W-1:0]  m_tuser
);

    logic               top_valid;
    logic [ENTRY_W-1:0] entry_count;

    assign top_valid   = m_tdata[KEY_W];
    assign entry_count = m_tdata[KEY_W+1 +: ENTRY_W];

    // a stalled result beat stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // top flag follows the count, empty heap shows key zero
    a_top: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (top_valid == (entry_count != '0))
                     && (top_valid || m_tdata[KEY_W-1:0] == '0))
        else $error("top flag or key disagrees with entry count");

    // an empty pop reports an empty heap
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_EMPTY |-> entry_count == '0)
        else $error("empty status with entries held");

    // a dropped push reports a full heap
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_FULL |-> entry_count == ENTRY_W'(CAPACITY))
        else $error("full status with heap not full");

    // no unused status code
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser == ST_DONE || m_tuser == ST_FULL || m_tuser == ST_EMPTY)
        else $error("undefined status code");

endmodule

bind binary_min_heap_queue bmhq_checker u_bmhq_checker (.*);
